// File: hw/rtl/rcbd_pkg.sv
package rcbd_pkg;

  // Buffer depth of one frame and width of the running decimal value.
  localparam int FRAME_DEPTH = 50;
  localparam int VALUE_BITS  = 32;

  // Derived widths.
  localparam int POS_W   = $clog2(FRAME_DEPTH + 1);
  localparam int ACC_EXT = VALUE_BITS + 5;
  localparam int OUT_W   = 32;

  // Command and framing bytes.
  localparam logic [7:0] B_TURN_ON  = 8'h4B;
  localparam logic [7:0] B_TURN_OFF1 = 8'h49;
  localparam logic [7:0] B_TURN_OFF2 = 8'h4A;
  localparam logic [7:0] B_DIR_LO   = 8'h41;
  localparam logic [7:0] B_DIR_HI   = 8'h48;
  localparam logic [7:0] B_DIR_FWD  = 8'h45;
  localparam logic [7:0] B_RIGHT    = 8'h43;
  localparam logic [7:0] B_LEFT     = 8'h47;
  localparam logic [7:0] B_OPEN     = 8'h7B;
  localparam logic [7:0] B_CLOSE    = 8'h7D;
  localparam logic [7:0] B_HASH     = 8'h23;
  localparam logic [7:0] B_REPORT   = 8'h50;
  localparam logic [7:0] B_SAVE     = 8'h57;
  localparam logic [7:0] B_ZERO     = 8'h30;
  localparam logic [7:0] B_SLOT_HI  = 8'h36;
  localparam logic [7:0] B_DIR_MAXRAW = 8'h08;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic                         turn_mode;
    logic [3:0]                   direction;
    logic                         left;
    logic                         right;
    logic                         collecting;
    logic [POS_W-1:0]             pos;
    logic [7:0]                   id;
    logic [7:0]                   selector;
    logic signed [VALUE_BITS-1:0] acc;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic              save_request;
    logic              report_request;
    logic [OUT_W-1:0]  param_value;
    logic [2:0]        param_index;
    logic              param_write;
    logic              steer_right;
    logic              steer_left;
    logic              turn_mode;
    logic [3:0]        direction;
  } dec_result_t;

endpackage

// File: hw/rtl/rcbd_step.sv
module rcbd_step (
  input  logic                 drive_disabled,
  input  logic [7:0]           rx_byte,
  input  rcbd_pkg::dec_state_t st,
  output rcbd_pkg::dec_state_t st_nxt,
  output rcbd_pkg::dec_result_t res
);

  logic                                  turn_nxt;
  logic signed [9:0]                     digit;
  logic signed [rcbd_pkg::ACC_EXT-1:0]   acc_x;
  logic signed [rcbd_pkg::ACC_EXT-1:0]   mac_sum;
  logic [rcbd_pkg::ACC_EXT-rcbd_pkg::VALUE_BITS:0] mac_top;
  logic signed [rcbd_pkg::VALUE_BITS-1:0] mac_sat;
  logic                                  in_frame;

  // Turn mode follows its enter and leave bytes.
  always_comb begin
    turn_nxt = st.turn_mode;
    if (rx_byte == rcbd_pkg::B_TURN_ON) begin
      turn_nxt = 1'b1;
    end else if (rx_byte == rcbd_pkg::B_TURN_OFF1 || rx_byte == rcbd_pkg::B_TURN_OFF2) begin
      turn_nxt = 1'b0;
    end
  end

  // Saturating value*10 + (byte - '0'), done with shifts and two adds.
  always_comb begin
    digit   = $signed({2'b00, rx_byte}) - $signed({2'b00, rcbd_pkg::B_ZERO});
    acc_x   = rcbd_pkg::ACC_EXT'(st.acc);
    mac_sum = (acc_x <<< 3) + (acc_x <<< 1) + rcbd_pkg::ACC_EXT'(digit);
    mac_top = mac_sum[rcbd_pkg::ACC_EXT-1:rcbd_pkg::VALUE_BITS-1];
    if ((&mac_top) || !(|mac_top)) begin
      mac_sat = mac_sum[rcbd_pkg::VALUE_BITS-1:0];
    end else if (mac_sum[rcbd_pkg::ACC_EXT-1]) begin
      mac_sat = {1'b1, {(rcbd_pkg::VALUE_BITS-1){1'b0}}};
    end else begin
      mac_sat = {1'b0, {(rcbd_pkg::VALUE_BITS-1){1'b1}}};
    end
  end

  // Drive decode, frame collection and result assembly.
  always_comb begin
    st_nxt           = st;
    st_nxt.turn_mode = turn_nxt;
    res              = '0;

    if (!drive_disabled) begin
      if (!turn_nxt) begin
        if (rx_byte inside {[rcbd_pkg::B_DIR_LO:rcbd_pkg::B_DIR_HI]} ||
            rx_byte <= rcbd_pkg::B_DIR_MAXRAW) begin
          // Low nibble gives the code for both the letter and the raw range.
          st_nxt.direction = rx_byte[3:0];
        end else begin
          st_nxt.direction = 4'd0;
        end
      end else begin
        st_nxt.left  = (rx_byte == rcbd_pkg::B_LEFT);
        st_nxt.right = (rx_byte == rcbd_pkg::B_RIGHT);
        if (rx_byte inside {rcbd_pkg::B_DIR_LO, rcbd_pkg::B_DIR_FWD}) begin
          st_nxt.direction = rx_byte[3:0];
        end else begin
          st_nxt.direction = 4'd0;
        end
      end
    end

    in_frame = st.collecting || (rx_byte == rcbd_pkg::B_OPEN);
    st_nxt.collecting = in_frame;

    if (rx_byte == rcbd_pkg::B_CLOSE) begin
      // Closing brace: raise a request or a parameter write, then clear.
      if (st.selector == rcbd_pkg::B_REPORT) begin
        res.report_request = 1'b1;
      end else if (st.selector == rcbd_pkg::B_SAVE) begin
        res.save_request = 1'b1;
      end else if (st.id != rcbd_pkg::B_HASH &&
                   st.id inside {[rcbd_pkg::B_ZERO:rcbd_pkg::B_SLOT_HI]}) begin
        res.param_write = 1'b1;
        res.param_index = st.id[2:0];
        res.param_value = rcbd_pkg::OUT_W'(st.acc);
      end
      st_nxt.collecting = 1'b0;
      st_nxt.pos        = '0;
      st_nxt.id         = '0;
      st_nxt.selector   = '0;
      st_nxt.acc        = '0;
    end else if (in_frame && st.pos < rcbd_pkg::POS_W'(rcbd_pkg::FRAME_DEPTH)) begin
      if (st.pos == rcbd_pkg::POS_W'(1)) begin
        st_nxt.id = rx_byte;
      end
      if (st.pos == rcbd_pkg::POS_W'(3)) begin
        st_nxt.selector = rx_byte;
      end
      if (st.pos >= rcbd_pkg::POS_W'(3)) begin
        st_nxt.acc = mac_sat;
      end
      st_nxt.pos = st.pos + rcbd_pkg::POS_W'(1);
    end

    res.direction   = st_nxt.direction;
    res.turn_mode   = st_nxt.turn_mode;
    res.steer_left  = st_nxt.left;
    res.steer_right = st_nxt.right;
  end

endmodule

// File: hw/rtl/remote_command_byte_decoder_unit.sv
// A byte taken into the input register is decoded and its result is loaded into
// the result register, ready for transfer. One byte is taken per cycle while the
// result slot is free or being read out; the decode and the value update sit in
// one short combinational step between the two registers.
// Reset (rst_n low, synchronous): both registers empty, decoder state and
// the drive_disabled register cleared.
module remote_command_byte_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: drive_disabled
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] direction, [4] turn_mode, [5] steer_left, [6] steer_right,
  // [7] param_write, [10:8] param_index, [42:11] param_value,
  // [43] report_request, [44] save_request, [47:45] zero
  output logic [47:0] out_tdata
);

  logic                  drive_disabled_r;
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  logic [7:0]            in_byte_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  rcbd_pkg::dec_result_t out_res_r;
  rcbd_pkg::dec_state_t  state_r;
  rcbd_pkg::dec_state_t  state_nxt;
  rcbd_pkg::dec_result_t step_res;
  logic                  advance;

  rcbd_step u_step (
    .drive_disabled (drive_disabled_r),
    .rx_byte        (in_byte_r),
    .st             (state_r),
    .st_nxt         (state_nxt),
    .res            (step_res)
  );

  // Handshake: the held byte moves on whenever the result slot is free.
  assign advance       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !in_valid_r || advance;
  assign in_valid_nxt  = (in_tvalid && in_tready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_disabled_r <= 1'b0;
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r          <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        drive_disabled_r <= cfg_wdata;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  // A held byte with a free result slot always yields a result next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("byte advanced but no result was presented");

  // A waiting result must not be overwritten.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_res_r))
    else $error("stalled result changed");

  // A parameter write excludes both requests and uses a valid slot.
  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.param_write) |->
      (!out_res_r.report_request && !out_res_r.save_request &&
       out_res_r.param_index <= 3'd6))
    else $error("inconsistent parameter write");

  // Frame position never passes the buffer depth.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pos <= rcbd_pkg::POS_W'(rcbd_pkg::FRAME_DEPTH))
    else $error("frame position beyond buffer depth");

  // Outside a frame nothing is collected.
  a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.collecting |-> (state_r.pos == '0 && state_r.acc == '0))
    else $error("frame state left over outside a frame");

endmodule
